// File: src/dvru_pkg.sv
package dvru_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned PORT_COUNT  = 4;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef logic [31:0] addr_t;
  typedef logic [4:0]  metric_t;
  typedef logic [1:0]  port_t;
  typedef logic [3:0]  link_t;
  typedef logic [3:0]  slot_t;
  typedef logic [2:0]  action_t;

  localparam metric_t METRIC_INF = 5'd16;

  localparam action_t ACT_UNCHANGED = 3'd0;
  localparam action_t ACT_IMPROVED  = 3'd1;
  localparam action_t ACT_DIRECT    = 3'd2;
  localparam action_t ACT_ADDED     = 3'd3;
  localparam action_t ACT_INSTALLED = 3'd4;
  localparam action_t ACT_FULL      = 3'd5;

  localparam logic OP_INSTALL = 1'b0;
  localparam logic OP_ADVERT  = 1'b1;

  typedef struct packed {
    addr_t   dest;
    addr_t   mask;
    addr_t   gateway;
    metric_t metric;
    port_t   port;
  } entry_t;

  typedef struct packed {
    action_t action;
    slot_t   slot;
    metric_t metric;
    logic    trig;
  } result_t;

  function automatic metric_t clamp_metric(metric_t m);
    return (m > METRIC_INF) ? METRIC_INF : m;
  endfunction

  // metric + 1, saturating at infinity
  function automatic metric_t inc_metric(metric_t m);
    return (m >= METRIC_INF) ? METRIC_INF : metric_t'(m + 5'd1);
  endfunction

endpackage

// File: src/distance_vector_route_update_core.sv
// Install item: the result is registered, then moved to the output register once it is free.
// Advertised item: the table memory is read one entry per cycle; the scan ends at the
// first matching slot or, with no match, after the last stored route, and the result
// then goes to the output register as for an install. The next item is taken only
// after the result has entered the output register.
// Reset clears the fill count, the pending-change flag and all control state;
// the table memory is not cleared, an empty fill count marks it empty.
module distance_vector_route_update_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // [31:0] route_address, [63:32] route_mask, [95:64] next_hop_ip,
  // [100:96] route_metric, [102:101] arrival_port, [106:103] link_up_mask, rest 0
  input  logic [111:0]  s_axis_tdata_i,
  input  logic          s_axis_tlast_i,   // last_entry
  input  logic          s_axis_tuser_i,   // op
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // [3:0] slot, [8:4] new_metric, [9] triggered_update, rest 0
  output logic [15:0]   m_axis_tdata_o,
  output logic [2:0]    m_axis_tuser_o    // action
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam int unsigned IDX_W = dvru_pkg::IDX_W;
  localparam int unsigned CNT_W = dvru_pkg::CNT_W;

  logic [1:0]           state_q, state_d;
  logic [CNT_W-1:0]     fill_q, fill_d;
  logic                 pend_q, pend_d;
  logic [CNT_W-1:0]     rd_idx_q, rd_idx_d;
  logic                 chk_valid_q, chk_valid_d;
  logic [IDX_W-1:0]     chk_idx_q, chk_idx_d;
  dvru_pkg::result_t    res_q, res_d;
  logic                 m_valid_q, m_valid_d;
  dvru_pkg::result_t    m_res_q, m_res_d;

  // held item
  dvru_pkg::addr_t      addr_q, mask_q, hop_q;
  dvru_pkg::metric_t    metric_q;
  dvru_pkg::port_t      port_q;
  dvru_pkg::link_t      links_q;
  logic                 last_q;

  // route table memory
  dvru_pkg::entry_t     rt_mem [dvru_pkg::TABLE_DEPTH];
  dvru_pkg::entry_t     rdata_q;
  logic                 mem_we, mem_re;
  logic [IDX_W-1:0]     mem_waddr;
  dvru_pkg::entry_t     mem_wdata;

  logic                 in_acc;
  dvru_pkg::addr_t      in_addr, in_mask, in_hop;
  dvru_pkg::metric_t    in_metric;
  dvru_pkg::port_t      in_port;
  dvru_pkg::link_t      in_links;

  logic                 full;
  dvru_pkg::metric_t    cand;
  dvru_pkg::entry_t     upd;
  dvru_pkg::action_t    act;
  logic                 changed;
  logic                 finish;
  logic                 pend_nx;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign in_addr   = s_axis_tdata_i[31:0];
  assign in_mask   = s_axis_tdata_i[63:32];
  assign in_hop    = s_axis_tdata_i[95:64];
  assign in_metric = dvru_pkg::clamp_metric(s_axis_tdata_i[100:96]);
  assign in_port   = s_axis_tdata_i[102:101];
  assign in_links  = s_axis_tdata_i[106:103];

  assign full = (fill_q == CNT_W'(dvru_pkg::TABLE_DEPTH));
  assign cand = dvru_pkg::inc_metric(metric_q);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    pend_d      = pend_q;
    rd_idx_d    = rd_idx_q;
    chk_valid_d = 1'b0;
    chk_idx_d   = chk_idx_q;
    res_d       = res_q;
    m_valid_d   = m_valid_q && !m_axis_tready_i;
    m_res_d     = m_res_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = fill_q[IDX_W-1:0];
    mem_wdata   = '0;
    upd         = rdata_q;
    act         = dvru_pkg::ACT_UNCHANGED;
    changed     = 1'b0;
    finish      = 1'b0;
    pend_nx     = pend_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i == dvru_pkg::OP_INSTALL) begin
            if (full) begin
              res_d = '{dvru_pkg::ACT_FULL, '0, '0, 1'b0};
            end else begin
              mem_we    = 1'b1;
              mem_wdata = '{in_addr, in_mask, in_hop, in_metric, in_port};
              fill_d    = fill_q + 1'b1;
              res_d     = '{dvru_pkg::ACT_INSTALLED,
                            dvru_pkg::slot_t'(fill_q[IDX_W-1:0]), in_metric, 1'b0};
            end
            state_d = ST_DONE;
          end else begin
            rd_idx_d = '0;
            state_d  = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // read issue runs one entry ahead of the compare
        mem_re      = (rd_idx_q < fill_q);
        chk_valid_d = mem_re;
        chk_idx_d   = rd_idx_q[IDX_W-1:0];
        if (mem_re) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end

        if (chk_valid_q && rdata_q.dest == addr_q) begin
          finish = 1'b1;
          if (rdata_q.gateway != '0) begin
            if (rdata_q.metric > cand) begin
              upd.metric  = cand;
              upd.gateway = hop_q;
              upd.port    = port_q;
              act         = dvru_pkg::ACT_IMPROVED;
              changed     = 1'b1;
            end
          end else if (32'(rdata_q.port) < dvru_pkg::PORT_COUNT &&
                       links_q[rdata_q.port]) begin
            upd.metric = '0;
            act        = dvru_pkg::ACT_DIRECT;
          end
          mem_we    = (act != dvru_pkg::ACT_UNCHANGED);
          mem_waddr = chk_idx_q;
          mem_wdata = upd;
          res_d     = '{act, dvru_pkg::slot_t'(chk_idx_q), upd.metric, 1'b0};
        end else if (!chk_valid_q && !mem_re) begin
          // no match: append with the candidate metric via the sender
          finish = 1'b1;
          if (full) begin
            res_d = '{dvru_pkg::ACT_FULL, '0, '0, 1'b0};
          end else begin
            mem_we    = 1'b1;
            mem_wdata = '{addr_q, mask_q, hop_q, cand, port_q};
            fill_d    = fill_q + 1'b1;
            changed   = 1'b1;
            res_d     = '{dvru_pkg::ACT_ADDED,
                          dvru_pkg::slot_t'(fill_q[IDX_W-1:0]), cand, 1'b0};
          end
        end

        if (finish) begin
          pend_nx     = pend_q | changed;
          res_d.trig  = last_q & pend_nx;
          pend_d      = last_q ? 1'b0 : pend_nx;
          chk_valid_d = 1'b0;
          state_d     = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_res_d   = res_q;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      pend_q      <= 1'b0;
      rd_idx_q    <= '0;
      chk_valid_q <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      pend_q      <= pend_d;
      rd_idx_q    <= rd_idx_d;
      chk_valid_q <= chk_valid_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= chk_idx_d;
    res_q     <= res_d;
    m_res_q   <= m_res_d;
    if (in_acc) begin
      addr_q   <= in_addr;
      mask_q   <= in_mask;
      hop_q    <= in_hop;
      metric_q <= in_metric;
      port_q   <= in_port;
      links_q  <= in_links;
      last_q   <= s_axis_tlast_i;
    end
  end

  // one item in flight, so the write-back never overlaps a read of the same entry
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rt_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= rt_mem[rd_idx_q[IDX_W-1:0]];
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_res_q.action;
  assign m_axis_tdata_o  = {6'd0, m_res_q.trig, m_res_q.metric, m_res_q.slot};

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(dvru_pkg::TABLE_DEPTH))
    else $error("fill count past table depth");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> CNT_W'(mem_waddr) < fill_d)
    else $error("table write outside filled region");

  a_chk_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_valid_q |-> state_q == ST_SCAN)
    else $error("compare stage active outside scan");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && !chk_valid_q && rd_idx_q >= fill_q) |=> state_q == ST_DONE)
    else $error("scan did not end after last entry");

  a_install_no_trig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_res_q.action == dvru_pkg::ACT_INSTALLED) |-> !m_res_q.trig)
    else $error("install result carries triggered update");

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int N_RANDOM    = 480;
  localparam int POOL_SIZE   = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN       = 40;

  localparam dvru_pkg::addr_t NET_ZERO = 32'h0000_0000;
  localparam dvru_pkg::addr_t NET_ONES = 32'hffff_ffff;
  localparam dvru_pkg::addr_t NET_A    = 32'h0a0a_0000;
  localparam dvru_pkg::addr_t NET_B    = 32'h0b00_0000;
  localparam dvru_pkg::addr_t NET_C    = 32'h0c00_0000;

  typedef struct packed {
    logic              op;
    dvru_pkg::addr_t   addr;
    dvru_pkg::addr_t   mask;
    dvru_pkg::addr_t   hop;
    dvru_pkg::metric_t metric;
    dvru_pkg::port_t   port;
    dvru_pkg::link_t   links;
    logic              last;
  } route_item_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [111:0] s_axis_tdata_i = '0;
  logic         s_axis_tlast_i = 1'b0;
  logic         s_axis_tuser_i = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [15:0]  m_axis_tdata_o;
  logic [2:0]   m_axis_tuser_o;

  always #1 clk_i = ~clk_i;

  distance_vector_route_update_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // shadow route table
  logic              rt_valid [dvru_pkg::TABLE_DEPTH];
  dvru_pkg::addr_t   rt_dest  [dvru_pkg::TABLE_DEPTH];
  dvru_pkg::addr_t   rt_gw    [dvru_pkg::TABLE_DEPTH];
  dvru_pkg::metric_t rt_metric[dvru_pkg::TABLE_DEPTH];
  dvru_pkg::port_t   rt_port  [dvru_pkg::TABLE_DEPTH];
  int                rt_count = 0;
  logic              change_pending = 1'b0;

  route_item_t         pending_routes[$];
  dvru_pkg::result_t   expected_updates[$];

  route_item_t in_item = '0;
  logic        in_busy = 1'b0;
  logic        in_taken = 1'b0;
  logic        in_burst = 1'b0;
  int          in_gap = 0;

  logic        out_taken = 1'b0;
  logic        out_burst = 1'b0;
  logic        hold_done = 1'b0;
  int          out_wait = 0;
  int          results_seen = 0;

  int          error_count = 0;
  int          idle_cycles = 0;

  function automatic int next_wait(logic burst);
    return burst ? 0 : $urandom_range(0, 10);
  endfunction

  // returns slot written, or -1 when the table is full
  function automatic int append_route(dvru_pkg::addr_t dest, dvru_pkg::addr_t gw,
                                      dvru_pkg::metric_t m, dvru_pkg::port_t p);
    int s;
    s = rt_count;
    if (s >= dvru_pkg::TABLE_DEPTH) return -1;
    rt_valid[s]  = 1'b1;
    rt_dest[s]   = dest;
    rt_gw[s]     = gw;
    rt_metric[s] = m;
    rt_port[s]   = p;
    rt_count     = s + 1;
    return s;
  endfunction

  function automatic dvru_pkg::result_t apply_route(route_item_t it);
    dvru_pkg::result_t r;
    dvru_pkg::metric_t m;
    dvru_pkg::metric_t cand;
    int      hit;
    int      s;
    logic    changed;
    r = '0;
    hit = -1;
    changed = 1'b0;
    m = (it.metric > dvru_pkg::METRIC_INF) ? dvru_pkg::METRIC_INF : it.metric;
    cand = (m >= dvru_pkg::METRIC_INF) ? dvru_pkg::METRIC_INF
                                       : dvru_pkg::metric_t'(m + 5'd1);
    if (it.op == dvru_pkg::OP_INSTALL) begin
      s = append_route(it.addr, it.hop, m, it.port);
      if (s < 0) begin
        r.action = dvru_pkg::ACT_FULL;
      end else begin
        r.action = dvru_pkg::ACT_INSTALLED;
        r.slot   = dvru_pkg::slot_t'(s);
        r.metric = m;
      end
    end else begin
      for (int i = 0; i < dvru_pkg::TABLE_DEPTH; i++) begin
        if (hit < 0 && rt_valid[i] && rt_dest[i] == it.addr) hit = i;
      end
      if (hit >= 0) begin
        r.action = dvru_pkg::ACT_UNCHANGED;
        if (rt_gw[hit] != '0) begin
          if (rt_metric[hit] > cand) begin
            rt_metric[hit] = cand;
            rt_gw[hit]     = it.hop;
            rt_port[hit]   = it.port;
            r.action       = dvru_pkg::ACT_IMPROVED;
            changed        = 1'b1;
          end
        end else if (rt_port[hit] < dvru_pkg::PORT_COUNT && it.links[rt_port[hit]]) begin
          // direct refresh, not counted as a table change
          rt_metric[hit] = '0;
          r.action       = dvru_pkg::ACT_DIRECT;
        end
        r.slot   = dvru_pkg::slot_t'(hit);
        r.metric = rt_metric[hit];
      end else begin
        s = append_route(it.addr, it.hop, cand, it.port);
        if (s < 0) begin
          r.action = dvru_pkg::ACT_FULL;
        end else begin
          r.action = dvru_pkg::ACT_ADDED;
          r.slot   = dvru_pkg::slot_t'(s);
          r.metric = cand;
          changed  = 1'b1;
        end
      end
      if (changed) change_pending = 1'b1;
      if (it.last) begin
        r.trig = change_pending;
        change_pending = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic void check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
      error_count++;
    end
  endfunction

  task automatic add_route(logic op, dvru_pkg::addr_t addr, dvru_pkg::addr_t mask,
                           dvru_pkg::addr_t hop, dvru_pkg::metric_t metric,
                           dvru_pkg::port_t port, dvru_pkg::link_t links, logic last);
    route_item_t it;
    it = '{op: op, addr: addr, mask: mask, hop: hop, metric: metric, port: port,
           links: links, last: last};
    pending_routes.push_back(it);
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        in_busy  = 1'b0;
        in_taken = 1'b0;
      end
      if (!in_busy) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_routes.size() > 0) begin
          in_item = pending_routes.pop_front();
          in_busy = 1'b1;
          if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
          in_gap = next_wait(in_burst);
        end
      end
      s_axis_tvalid_i <= in_busy;
      s_axis_tdata_i  <= {5'b0, in_item.links, in_item.port, in_item.metric,
                          in_item.hop, in_item.mask, in_item.addr};
      s_axis_tlast_i  <= in_item.last;
      s_axis_tuser_i  <= in_item.op;
    end
  end

  // input transaction -> expected result
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      expected_updates.push_back(apply_route(in_item));
      in_taken = 1'b1;
    end
  end

  // receiver, with one long hold-off to back the block up
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        out_taken = 1'b0;
        if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
        out_wait = next_wait(out_burst);
        if (!hold_done && results_seen >= 150) begin
          hold_done = 1'b1;
          out_wait  = HOLD_CYCLES;
        end
      end
      if (out_wait > 0) begin
        out_wait--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      dvru_pkg::result_t exp_res;
      results_seen++;
      out_taken = 1'b1;
      if (expected_updates.size() == 0) begin
        $display("%0t: unexpected result, expected none actual action %0d tdata %h",
                 $time, m_axis_tuser_o, m_axis_tdata_o);
        error_count++;
      end else begin
        exp_res = expected_updates.pop_front();
        check_field("action", exp_res.action, m_axis_tuser_o);
        check_field("slot", exp_res.slot, m_axis_tdata_o[3:0]);
        check_field("new_metric", exp_res.metric, m_axis_tdata_o[8:4]);
        check_field("triggered_update", exp_res.trig, m_axis_tdata_o[9]);
      end
    end
  end

  // watchdog: cycles without any transaction on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $time, expected_updates.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    dvru_pkg::addr_t   pool[POOL_SIZE];
    dvru_pkg::addr_t   addr;
    dvru_pkg::addr_t   hop;
    dvru_pkg::metric_t metric;
    int                lo;

    for (int i = 0; i < dvru_pkg::TABLE_DEPTH; i++) rt_valid[i] = 1'b0;

    // directed: direct and learned routes, link up/down, saturation, packet ends
    add_route(dvru_pkg::OP_INSTALL, NET_ZERO, 32'hffff_ffff, 32'h0, 5'd0, 2'd0, 4'h0, 1'b0);
    add_route(dvru_pkg::OP_INSTALL, NET_ONES, 32'h0, 32'hffff_ffff, 5'd31, 2'd3, 4'hf,
              1'b1);
    add_route(dvru_pkg::OP_ADVERT, NET_ZERO, 32'hffff_0000, 32'h0a00_0001, 5'd5, 2'd0,
              4'h0, 1'b0);
    add_route(dvru_pkg::OP_ADVERT, NET_ZERO, 32'hffff_0000, 32'h0a00_0001, 5'd5, 2'd1,
              4'h1, 1'b0);
    add_route(dvru_pkg::OP_ADVERT, NET_ONES, 32'hffff_ffff, 32'h0a00_0002, 5'd3, 2'd2,
              4'hf, 1'b1);
    add_route(dvru_pkg::OP_ADVERT, NET_ONES, 32'hffff_ffff, 32'h0a00_0003, 5'd4, 2'd1,
              4'h0, 1'b1);
    add_route(dvru_pkg::OP_ADVERT, NET_A, 32'hffff_0000, 32'hc0a8_0001, 5'd16, 2'd1,
              4'h3, 1'b0);
    add_route(dvru_pkg::OP_ADVERT, NET_A, 32'hffff_0000, 32'hc0a8_0002, 5'd15, 2'd2,
              4'h3, 1'b0);
    add_route(dvru_pkg::OP_ADVERT, NET_A, 32'hffff_0000, 32'hc0a8_0003, 5'd31, 2'd0,
              4'h3, 1'b0);
    add_route(dvru_pkg::OP_ADVERT, NET_A, 32'hffff_0000, 32'hc0a8_0004, 5'd0, 2'd3,
              4'h3, 1'b1);
    add_route(dvru_pkg::OP_INSTALL, NET_B, 32'hff00_0000, 32'h0, 5'd16, 2'd3, 4'h0, 1'b0);
    add_route(dvru_pkg::OP_ADVERT, NET_B, 32'hff00_0000, 32'h0b00_0001, 5'd2, 2'd0,
              4'h7, 1'b0);
    add_route(dvru_pkg::OP_ADVERT, NET_B, 32'hff00_0000, 32'h0b00_0001, 5'd2, 2'd0,
              4'h8, 1'b1);
    add_route(dvru_pkg::OP_ADVERT, NET_C, 32'hff00_0000, 32'h0, 5'd2, 2'd1, 4'h0, 1'b0);
    add_route(dvru_pkg::OP_ADVERT, NET_C, 32'hff00_0000, 32'h0c00_0001, 5'd9, 2'd3,
              4'h2, 1'b1);
    // duplicate destination: the lower slot must keep matching
    add_route(dvru_pkg::OP_INSTALL, NET_A, 32'hffff_ff00, 32'h5555_5555, 5'd7, 2'd2,
              4'h0, 1'b0);
    add_route(dvru_pkg::OP_ADVERT, NET_A, 32'hffff_0000, 32'haaaa_aaaa, 5'd0, 2'd1,
              4'h5, 1'b1);

    pool[0] = NET_ZERO;
    pool[1] = NET_ONES;
    pool[2] = NET_A;
    pool[3] = NET_B;
    pool[4] = NET_C;
    for (int i = 5; i < POOL_SIZE; i++) pool[i] = $urandom;

    // random: mostly known destinations so entries get hit repeatedly;
    // metrics trend downward so improvements keep happening
    for (int k = 0; k < N_RANDOM; k++) begin
      lo = 16 - (k * 17) / N_RANDOM;
      addr = ($urandom_range(0, 6) == 0) ? dvru_pkg::addr_t'($urandom)
                                         : pool[$urandom_range(0, POOL_SIZE - 1)];
      hop = ($urandom_range(0, 3) == 0) ? dvru_pkg::addr_t'(0)
                                        : dvru_pkg::addr_t'($urandom);
      metric = ($urandom_range(0, 3) == 0) ? dvru_pkg::metric_t'($urandom_range(0, 31))
                                           : dvru_pkg::metric_t'($urandom_range(lo, 16));
      add_route(($urandom_range(0, 4) == 0) ? dvru_pkg::OP_INSTALL : dvru_pkg::OP_ADVERT,
                addr, dvru_pkg::addr_t'($urandom), hop, metric,
                dvru_pkg::port_t'($urandom_range(0, 3)),
                dvru_pkg::link_t'($urandom_range(0, 15)), $urandom_range(0, 3) == 0);
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_routes.size() > 0 || in_busy) @(posedge clk_i);
    while (expected_updates.size() > 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
src/dvru_pkg.sv
src/distance_vector_route_update_core.sv
test/tb.sv
